>>> src/lce_pkg.sv
// Package with the shared types, constants and helpers of the line code encoder.
`default_nettype none
package lce_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int MAX_SYMS    = 8;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMS);
    localparam int COUNT_W     = SYM_IDX_W + 1;

    localparam logic [2:0] MODE_NRZ_L      = 3'd0;
    localparam logic [2:0] MODE_NRZ_I      = 3'd1;
    localparam logic [2:0] MODE_MANCHESTER = 3'd2;
    localparam logic [2:0] MODE_DIFF_MAN   = 3'd3;
    localparam logic [2:0] MODE_AMI        = 3'd4;
    localparam logic [2:0] MODE_B8ZS       = 3'd5;
    localparam logic [2:0] MODE_HDB3       = 3'd6;

    localparam logic [1:0] SYM_POS  = 2'b01;
    localparam logic [1:0] SYM_ZERO = 2'b00;
    localparam logic [1:0] SYM_NEG  = 2'b11;

    localparam logic [2:0] B8ZS_LAST_ZERO = 3'd7;
    localparam logic [2:0] HDB3_LAST_ZERO = 3'd3;

    typedef struct packed {
        logic data_bit;
        logic end_of_message;
    } request_t;

    typedef struct packed {
        logic signed [1:0] symbol;
        logic              run_end;
    } result_t;

    typedef struct packed {
        logic [MAX_SYMS-1:0][1:0] syms;
        logic [COUNT_W-1:0]       count;
    } job_t;

    function automatic logic [1:0] level_sym(input logic high);
        level_sym = high ? SYM_POS : SYM_NEG;
    endfunction

endpackage
`default_nettype wire

>>> src/line_code_encoder_unit.sv
// Top level of the line code encoder: front, job queue and symbol back end.
//
//   Channel   Handshake          Payload
//   request   push / full        request (data_bit, end_of_message)
//   result    empty / pop        result (symbol, run_end)
//   config    cfg_we             cfg_data (mode)
//
// The front takes one request per cycle while the queue is not full and turns it into a job
// of zero to eight symbols. The back sends one symbol per cycle while pop is high; each job
// it sends has at least one symbol: two in the Manchester modes, up to eight for a scrambled run.
// Requests with no symbol never enter the four-entry job queue; full rises when it holds four.
// Reset clears the mode, the line state and the queue at once.
`default_nettype none
module line_code_encoder_unit
    import lce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire request_t   request,
    output logic            empty,
    input  wire logic       pop,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_data
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_wr_data;
    job_t q_rd_data;

    assign full = q_full;

    lce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr_data)
    );

    lce_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    lce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .result  (result),
        .pop     (pop)
    );

endmodule
`default_nettype wire

>>> src/lce_queue.sv
// Short queue of symbol jobs between the front and the back of the encoder.
`default_nettype none
module lce_queue
    import lce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_data,
    output logic      empty
);

    job_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    fill_reg;
    logic [QUEUE_AW:0]    fill_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> src/lce_front.sv
// Front of the encoder: holds the mode and line state and turns each request into a symbol job.
`default_nettype none
module lce_front
    import lce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire request_t   request,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_data,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_data
);

    logic [2:0] mode_reg;
    logic       level_reg;
    logic       level_next;
    logic       polarity_reg;
    logic       polarity_next;
    logic [2:0] zero_run_reg;
    logic [2:0] zero_run_next;
    logic       parity_reg;
    logic       parity_next;

    logic [MAX_SYMS-1:0][1:0] syms;
    logic [COUNT_W-1:0]       count;
    logic [2:0]               offset;
    logic                     accept;

    assign accept = push && !q_full;

    always_comb
    begin
        syms          = '0;
        count         = '0;
        offset        = '0;
        level_next    = level_reg;
        polarity_next = polarity_reg;
        zero_run_next = zero_run_reg;
        parity_next   = parity_reg;

        unique case (mode_reg)
            MODE_NRZ_I:
            begin
                level_next = level_reg ^ request.data_bit;
                syms[0]    = level_sym(level_next);
                count      = COUNT_W'(1);
            end
            MODE_MANCHESTER:
            begin
                syms[0] = level_sym(!request.data_bit);
                syms[1] = level_sym(request.data_bit);
                count   = COUNT_W'(2);
            end
            MODE_DIFF_MAN:
            begin
                if (request.data_bit)
                begin
                    syms[0]    = level_sym(level_reg);
                    syms[1]    = level_sym(!level_reg);
                    level_next = !level_reg;
                end
                else
                begin
                    syms[0] = level_sym(!level_reg);
                    syms[1] = level_sym(level_reg);
                end
                count = COUNT_W'(2);
            end
            MODE_AMI:
            begin
                if (request.data_bit)
                begin
                    polarity_next = !polarity_reg;
                    syms[0]       = level_sym(!polarity_reg);
                end
                count = COUNT_W'(1);
            end
            MODE_B8ZS:
            begin
                if (request.data_bit)
                begin
                    syms[zero_run_reg] = level_sym(!polarity_reg);
                    count              = {1'b0, zero_run_reg} + 1'b1;
                    zero_run_next      = '0;
                    polarity_next      = !polarity_reg;
                end
                else if (zero_run_reg == B8ZS_LAST_ZERO)
                begin
                    zero_run_next = '0;
                    syms[3]       = level_sym(polarity_reg);
                    syms[4]       = level_sym(!polarity_reg);
                    syms[6]       = level_sym(!polarity_reg);
                    syms[7]       = level_sym(polarity_reg);
                    count         = COUNT_W'(MAX_SYMS);
                end
                else
                begin
                    zero_run_next = zero_run_reg + 1'b1;
                end
            end
            MODE_HDB3:
            begin
                if (request.data_bit)
                begin
                    syms[zero_run_reg] = level_sym(!polarity_reg);
                    count              = {1'b0, zero_run_reg} + 1'b1;
                    zero_run_next      = '0;
                    polarity_next      = !polarity_reg;
                    parity_next        = !parity_reg;
                end
                else if (zero_run_reg >= HDB3_LAST_ZERO)
                begin
                    // Zeros beyond three in the pending run go out ahead of the substitution.
                    offset        = zero_run_reg - HDB3_LAST_ZERO;
                    count         = {1'b0, offset} + COUNT_W'(4);
                    zero_run_next = '0;
                    parity_next   = 1'b0;
                    if (!parity_reg)
                    begin
                        polarity_next         = !polarity_reg;
                        syms[offset]          = level_sym(!polarity_reg);
                        syms[offset + 3'd3]   = level_sym(!polarity_reg);
                    end
                    else
                    begin
                        syms[offset + 3'd3] = level_sym(polarity_reg);
                    end
                end
                else
                begin
                    zero_run_next = zero_run_reg + 1'b1;
                end
            end
            default:
            begin
                syms[0] = level_sym(request.data_bit);
                count   = COUNT_W'(1);
            end
        endcase

        if (request.end_of_message)
        begin
            count         = count + {1'b0, zero_run_next};
            level_next    = (mode_reg == MODE_DIFF_MAN);
            polarity_next = 1'b0;
            zero_run_next = '0;
            parity_next   = 1'b0;
        end
    end

    assign q_push     = accept && (count != '0);
    assign q_data.syms  = syms;
    assign q_data.count = count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NRZ_L;
            level_reg    <= 1'b0;
            polarity_reg <= 1'b0;
            zero_run_reg <= '0;
            parity_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg     <= cfg_data;
            zero_run_reg <= '0;
        end
        else if (accept)
        begin
            level_reg    <= level_next;
            polarity_reg <= polarity_next;
            zero_run_reg <= zero_run_next;
            parity_reg   <= parity_next;
        end
    end

endmodule
`default_nettype wire

>>> src/lce_back.sv
// Back of the encoder: sends the symbols of the oldest job one per cycle while pop is high.
`default_nettype none
module lce_back
    import lce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t q_data,
    input  wire logic q_empty,
    output logic      q_pop,
    output logic      empty,
    output result_t   result,
    input  wire logic pop
);

    logic [SYM_IDX_W-1:0] idx_reg;
    logic                 last;
    logic                 take;

    assign last           = (({1'b0, idx_reg} + 1'b1) == q_data.count);
    assign empty          = q_empty;
    assign take           = pop && !q_empty;
    assign q_pop          = take && last;
    assign result.symbol  = q_data.syms[idx_reg];
    assign result.run_end = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
